/* hw/rtl/sowtc_pkg.sv */
// Shared types and constants for the selectable-organization write-through cache.
package sowtc_pkg;

  localparam int unsigned LineCount  = 8;
  localparam int unsigned LineWords  = 4;
  localparam int unsigned StoreWords = 512;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ORG_DIRECT = 2'd0,
    ORG_TWO_WAY = 2'd1,
    ORG_FULL   = 2'd2,
    ORG_NONE   = 2'd3
  } org_t;

  localparam logic [31:0] CostReadHit   = 32'd2;
  localparam logic [31:0] CostReadMiss  = 32'd106;
  localparam logic [31:0] CostWriteHit  = 32'd102;
  localparam logic [31:0] CostWriteMiss = 32'd204;

  // one queued command between front and back
  typedef struct packed {
    mode_t       mode;
    logic [31:0] address;
    logic [31:0] write_data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOOKUP,
    ST_STWR,
    ST_FILL,
    ST_DONE
  } back_state_t;

  // result beat
  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
    logic [31:0] miss_total;
    logic [31:0] cycle_total;
  } res_t;

endpackage

/* hw/rtl/sowtc_queue.sv */
// Small two-entry FIFO used between the front and back and on the result side.
module sowtc_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             empty
);
  logic [Width-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

/* hw/rtl/sowtc_back.sv */
// Back end: tag lookup, store access, line refill and counters.
module sowtc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         org,
  input  logic               cmd_valid,
  input  sowtc_pkg::cmd_t    cmd,
  output logic               cmd_pop,
  output logic               res_push,
  output sowtc_pkg::res_t    res,
  input  logic               res_full,
  output logic               busy
);
  import sowtc_pkg::*;

  localparam int unsigned SAw = $clog2(StoreWords);

  back_state_t state_r, state_nxt;

  logic [29:0] tag_r   [LineCount];
  logic        valid_r [LineCount];
  logic [15:0] use_r   [LineCount];
  logic [31:0] words_r [LineCount*LineWords];
  logic [31:0] store_r [StoreWords];
  logic [SAw-1:0] clr_r;   // store clearing pass after reset

  logic [31:0] miss_r, cyc_r;
  cmd_t        cmd_r;
  logic        hit_r;
  logic [2:0]  line_r;
  logic [29:0] ntag_r;
  logic [2:0]  fcnt_r;   // fill word index, bit 2 = done
  logic [1:0]  rw_r;
  logic [31:0] rd_r;

  // lookup
  logic [29:0] tag_c;
  logic [2:0]  hline_c, vic_c;
  logic        hit_c;
  logic [1:0]  s2;
  logic [2:0]  d;
  logic [15:0] minc;

  always_comb begin
    tag_c   = '0;
    hline_c = '0;
    vic_c   = '0;
    hit_c   = 1'b0;
    s2      = cmd_r.address[3:2];
    d       = cmd_r.address[4:2];
    minc    = use_r[0];
    unique case (org_t'(org))
      ORG_DIRECT: begin
        tag_c   = {3'b0, cmd_r.address[31:5]};
        vic_c   = d;
        hline_c = d;
        hit_c   = valid_r[d] && tag_r[d] == tag_c;
      end
      ORG_TWO_WAY: begin
        tag_c = {2'b0, cmd_r.address[31:4]};
        vic_c = (use_r[{1'b0, s2}] <= use_r[{1'b1, s2}]) ? {1'b0, s2} : {1'b1, s2};
        if (valid_r[{1'b0, s2}] && tag_r[{1'b0, s2}] == tag_c) begin
          hit_c = 1'b1; hline_c = {1'b0, s2};
        end else if (valid_r[{1'b1, s2}] && tag_r[{1'b1, s2}] == tag_c) begin
          hit_c = 1'b1; hline_c = {1'b1, s2};
        end
      end
      ORG_FULL: begin
        tag_c = cmd_r.address[31:2];
        for (int i = 1; i < LineCount; i++) begin
          if (use_r[i] < minc) begin
            minc  = use_r[i];
            vic_c = 3'(i);
          end
        end
        for (int i = LineCount - 1; i >= 0; i--) begin
          if (valid_r[i] && tag_r[i] == tag_c) begin
            hit_c = 1'b1; hline_c = 3'(i);
          end
        end
      end
      default: ;
    endcase
  end

  logic active;
  assign active = (cmd_r.mode == MODE_READ || cmd_r.mode == MODE_WRITE)
                  && org_t'(org) != ORG_NONE;

  logic [SAw-1:0] faddr;
  assign faddr = SAw'({cmd_r.address[31:2], 2'b00} + {30'b0, fcnt_r[1:0]});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:    if (clr_r == SAw'(StoreWords - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (cmd_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (!active) state_nxt = ST_DONE;
        else if (cmd_r.mode == MODE_WRITE) state_nxt = ST_STWR;
        else if (hit_c) state_nxt = ST_DONE;
        else state_nxt = ST_FILL;
      end
      ST_STWR:   state_nxt = hit_r ? ST_DONE : ST_FILL;
      ST_FILL:   if (fcnt_r[2]) state_nxt = ST_DONE;
      ST_DONE:   if (!res_full) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state_r == ST_IDLE) && cmd_valid;
    res_push = (state_r == ST_DONE) && !res_full;
    busy     = (state_r != ST_IDLE);
    res.read_data   = (cmd_r.mode == MODE_READ && active) ?
                      words_r[{line_r, cmd_r.address[1:0]}] : 32'd0;
    res.hit         = hit_r;
    res.miss_total  = miss_r;
    res.cycle_total = cyc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_r      <= '0;
      miss_r     <= '0;
      cyc_r      <= '0;
      hit_r      <= 1'b0;
      for (int i = 0; i < LineCount; i++) begin
        tag_r[i]   <= '0;
        valid_r[i] <= 1'b0;
        use_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + SAw'(1);
        end
        ST_IDLE: begin
          hit_r  <= 1'b0;
          fcnt_r <= '0;
        end
        ST_LOOKUP: begin
          if (cmd_r.mode == MODE_CLEAR) begin
            miss_r <= '0;
            cyc_r  <= '0;
          end else if (active) begin
            hit_r  <= hit_c;
            line_r <= hit_c ? hline_c : vic_c;
            ntag_r <= tag_c;
            if (hit_c) begin
              cyc_r <= cyc_r + ((cmd_r.mode == MODE_READ) ? CostReadHit : CostWriteHit);
              if ((org_t'(org) == ORG_TWO_WAY ||
                   (org_t'(org) == ORG_FULL && cmd_r.mode == MODE_READ))
                  && use_r[hline_c] != 16'hFFFF)
                use_r[hline_c] <= use_r[hline_c] + 16'd1;
            end else begin
              miss_r <= miss_r + 32'd1;
              cyc_r  <= cyc_r + ((cmd_r.mode == MODE_READ) ? CostReadMiss : CostWriteMiss);
            end
          end
        end
        ST_STWR: begin
          if (hit_r) words_r[{line_r, cmd_r.address[1:0]}] <= cmd_r.write_data;
        end
        ST_FILL: begin
          // one store read issued per cycle, data lands in the next cycle
          if (!fcnt_r[2]) begin
            rd_r   <= store_r[faddr];
            rw_r   <= fcnt_r[1:0];
            fcnt_r <= fcnt_r + 3'd1;
          end
          if (fcnt_r != 3'd0)
            words_r[{line_r, rw_r}] <= rd_r;
          if (fcnt_r[2]) begin
            tag_r[line_r]   <= ntag_r;
            valid_r[line_r] <= 1'b1;
            if (org_t'(org) == ORG_FULL && use_r[line_r] != 16'hFFFF)
              use_r[line_r] <= use_r[line_r] + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // fill writes in ST_FILL trail the store reads through rd_r; last word written as state leaves
  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    if (state_r == ST_CLR) store_r[clr_r] <= '0;
    else if (state_r == ST_STWR) store_r[SAw'(cmd_r.address)] <= cmd_r.write_data;
  end
endmodule

/* hw/rtl/selectable_org_write_through_cache.sv */
// Top level: selectable-organization write-through cache with queue ports.
// A miss refills the line: four words are read from the store, one per cycle.
// The back end handles one access at a time and takes a new command only when idle.
// Reset (synchronous, rst_n low): lines invalid, counts and counters zero,
// organization direct mapped; a pass then zeroes all 512 store words, no beat taken.
module selectable_org_write_through_cache (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_organization,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_address,
  input  logic signed [31:0]  in_write_data,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_read_data,
  output logic                out_hit,
  output logic [31:0]         out_miss_total,
  output logic [31:0]         out_cycle_total
);
  import sowtc_pkg::*;

  logic [1:0] org_r;
  cmd_t       cmd_in, cmd_q;
  logic       cq_empty, cq_pop;
  res_t       res_b, res_q;
  logic       rq_push, rq_full, busy;

  always_ff @(posedge clk) begin
    if (!rst_n) org_r <= 2'd0;
    else if (cfg_we) org_r <= cfg_organization;
  end

  // front: command beats go into a short queue
  assign cmd_in.mode       = mode_t'(in_mode);
  assign cmd_in.address    = in_address;
  assign cmd_in.write_data = in_write_data;

  sowtc_queue #(.Width($bits(cmd_t))) u_cq (
    .clk, .rst_n, .push, .push_data(cmd_in), .full,
    .pop(cq_pop), .pop_data(cmd_q), .empty(cq_empty)
  );

  sowtc_back u_back (
    .clk, .rst_n, .org(org_r), .cmd_valid(!cq_empty), .cmd(cmd_q),
    .cmd_pop(cq_pop), .res_push(rq_push), .res(res_b), .res_full(rq_full),
    .busy
  );

  // result beats queue so the back end never waits on pop directly
  sowtc_queue #(.Width($bits(res_t))) u_rq (
    .clk, .rst_n, .push(rq_push), .push_data(res_b), .full(rq_full),
    .pop, .pop_data(res_q), .empty
  );

  assign out_read_data   = res_q.read_data;
  assign out_hit         = res_q.hit;
  assign out_miss_total  = res_q.miss_total;
  assign out_cycle_total = res_q.cycle_total;

`ifndef ASSERT_OFF
  a_pop_hit_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_hit) |-> (out_cycle_total != 32'd0))
    else $error("hit beat with zero cycle total");
  a_cmd_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !rq_push)
    else $error("command taken while result pushed");
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> busy)
    else $error("result pushed with back end idle");
`endif
endmodule

/* dv/tb.sv */
// Testbench for the selectable-organization write-through cache.
`timescale 1ns / 1ps

module tb;
  import sowtc_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_organization = 2'd0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_mode = 2'd0;
  logic [31:0] in_address = '0;
  logic signed [31:0] in_write_data = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] out_read_data;
  logic out_hit;
  logic [31:0] out_miss_total;
  logic [31:0] out_cycle_total;

  selectable_org_write_through_cache dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_organization(cfg_organization),
    .push(push), .full(full), .in_mode(in_mode), .in_address(in_address),
    .in_write_data(in_write_data), .empty(empty), .pop(pop),
    .out_read_data(out_read_data), .out_hit(out_hit),
    .out_miss_total(out_miss_total), .out_cycle_total(out_cycle_total)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cache state, advanced when a beat is pushed.
  org_t        org_q;
  logic [29:0] tag_q [8];
  logic        valid_q [8];
  logic [15:0] use_q [8];
  logic [31:0] words_q [8][4];
  logic [31:0] store_q [StoreWords];
  logic [31:0] misses_q, cycles_q;

  cmd_t cmd_pending [$];
  res_t access_expected [$];
  int   fails = 0;

  function automatic void bump_use(int ln);
    if (use_q[ln] != 16'hFFFF) use_q[ln]++;
  endfunction

  // Predict the result of one access and advance the shadow state.
  function automatic res_t cache_access(cmd_t c);
    res_t r;
    logic [31:0] a, tg, base;
    int ln, victim, s, w;
    a = c.address;
    r = '0;
    ln = -1;
    w = a[1:0];
    if (c.mode == MODE_CLEAR) begin
      misses_q = 0;
      cycles_q = 0;
    end else if (c.mode != MODE_NONE && org_q != ORG_NONE) begin
      if (org_q == ORG_DIRECT) begin
        victim = a[4:2];
        tg = a >> 5;
        if (valid_q[victim] && tag_q[victim] == tg[29:0]) ln = victim;
      end else if (org_q == ORG_TWO_WAY) begin
        s = a[3:2];
        tg = a >> 4;
        victim = (use_q[s] <= use_q[s + 4]) ? s : s + 4;
        if (valid_q[s] && tag_q[s] == tg[29:0]) ln = s;
        else if (valid_q[s + 4] && tag_q[s + 4] == tg[29:0]) ln = s + 4;
      end else begin
        tg = a >> 2;
        victim = 0;
        for (int i = 1; i < 8; i++) if (use_q[i] < use_q[victim]) victim = i;
        for (int i = 7; i >= 0; i--) if (valid_q[i] && tag_q[i] == tg[29:0]) ln = i;
      end
      if (ln >= 0) begin
        r.hit = 1'b1;
        if (c.mode == MODE_READ) begin
          r.read_data = words_q[ln][w];
          if (org_q != ORG_DIRECT) bump_use(ln);
          cycles_q += CostReadHit;
        end else begin
          words_q[ln][w] = c.write_data;
          store_q[a % StoreWords] = c.write_data;
          if (org_q == ORG_TWO_WAY) bump_use(ln);
          cycles_q += CostWriteHit;
        end
      end else begin
        misses_q++;
        if (c.mode == MODE_WRITE) store_q[a % StoreWords] = c.write_data;
        base = {a[31:2], 2'b00};
        for (int i = 0; i < 4; i++) words_q[victim][i] = store_q[(base + i) % StoreWords];
        tag_q[victim] = tg[29:0];
        valid_q[victim] = 1'b1;
        if (org_q == ORG_FULL) bump_use(victim);
        if (c.mode == MODE_READ) begin
          r.read_data = words_q[victim][w];
          cycles_q += CostReadMiss;
        end else begin
          cycles_q += CostWriteMiss;
        end
      end
    end
    r.miss_total = misses_q;
    r.cycle_total = cycles_q;
    return r;
  endfunction

  // Driver: one beat at a time, with a random idle gap before each.
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        access_expected.push_back(cache_access(cmd_pending.pop_front()));
        gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
        gap--;
        push <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        push <= 1'b1;
        in_mode <= cmd_pending[0].mode;
        in_address <= cmd_pending[0].address;
        in_write_data <= cmd_pending[0].write_data;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pop with a random wait between beats, compare every field.
  res_t got, exp_r;
  int pop_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        got = '{out_read_data, out_hit, out_miss_total, out_cycle_total};
        if (access_expected.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fails++;
        end else begin
          exp_r = access_expected.pop_front();
          if (got.read_data !== exp_r.read_data) begin
            $display("%0t: read_data exp %h got %h", $time, exp_r.read_data, got.read_data);
            fails++;
          end
          if (got.hit !== exp_r.hit) begin
            $display("%0t: hit exp %b got %b", $time, exp_r.hit, got.hit);
            fails++;
          end
          if (got.miss_total !== exp_r.miss_total) begin
            $display("%0t: miss_total exp %0d got %0d", $time, exp_r.miss_total,
                     got.miss_total);
            fails++;
          end
          if (got.cycle_total !== exp_r.cycle_total) begin
            $display("%0t: cycle_total exp %0d got %0d", $time, exp_r.cycle_total,
                     got.cycle_total);
            fails++;
          end
        end
        pop_gap = $urandom_range(0, 3);
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat moving on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cmd_t mk(mode_t m, logic [31:0] a, logic [31:0] d);
    cmd_t c;
    c.mode = m;
    c.address = a;
    c.write_data = d;
    return c;
  endfunction

  // Addresses mostly inside a small window so lines get reused.
  function automatic cmd_t rand_cmd();
    logic [31:0] a;
    int k;
    mode_t m;
    k = $urandom_range(0, 99);
    if (k < 70) a = $urandom_range(0, 63);
    else if (k < 85) a = $urandom_range(0, 1023);
    else a = $urandom;
    k = $urandom_range(0, 99);
    m = (k < 50) ? MODE_READ : (k < 94) ? MODE_WRITE : (k < 97) ? MODE_CLEAR : MODE_NONE;
    return mk(m, a, $urandom);
  endfunction

  task automatic drain();
    wait (cmd_pending.size() == 0 && !push);
    wait (access_expected.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Config is written only while the cache is idle.
  task automatic set_org(org_t o);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_organization <= o;
    org_q = o;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    org_t orgs [6];
    org_q = ORG_DIRECT;
    misses_q = 0;
    cycles_q = 0;
    for (int i = 0; i < 8; i++) begin
      tag_q[i] = '0;
      valid_q[i] = 1'b0;
      use_q[i] = '0;
      for (int j = 0; j < 4; j++) words_q[i][j] = '0;
    end
    for (int i = 0; i < StoreWords; i++) store_q[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: misses, hits, conflicts, extremes, clear and unused codes.
    cmd_pending.push_back(mk(MODE_READ, 32'd0, 32'd0));
    cmd_pending.push_back(mk(MODE_WRITE, 32'd1, 32'h7FFFFFFF));
    cmd_pending.push_back(mk(MODE_READ, 32'd1, 32'd0));
    cmd_pending.push_back(mk(MODE_WRITE, 32'hFFFFFFFF, 32'h80000000));
    cmd_pending.push_back(mk(MODE_READ, 32'hFFFFFFFF, 32'hFFFFFFFF));
    cmd_pending.push_back(mk(MODE_READ, 32'd32, 32'd0));
    cmd_pending.push_back(mk(MODE_READ, 32'd0, 32'd0));
    cmd_pending.push_back(mk(MODE_WRITE, 32'd513, 32'h12345678));
    cmd_pending.push_back(mk(MODE_READ, 32'd1, 32'd0));
    cmd_pending.push_back(mk(MODE_NONE, 32'hAAAAAAAA, 32'h55555555));
    cmd_pending.push_back(mk(MODE_CLEAR, 32'h55555555, 32'hAAAAAAAA));
    cmd_pending.push_back(mk(MODE_READ, 32'd2, 32'd0));
    drain();

    // The sender waits for all results between phases.
    orgs = '{ORG_TWO_WAY, ORG_FULL, ORG_NONE, ORG_DIRECT, ORG_FULL, ORG_TWO_WAY};
    foreach (orgs[p]) begin
      set_org(orgs[p]);
      for (int i = 0; i < 4; i++)
        cmd_pending.push_back(mk(MODE_WRITE, i * 16, $urandom));
      for (int i = 0; i < 6; i++)
        cmd_pending.push_back(mk(MODE_READ, i * 4, 0));
      for (int i = 0; i < 210; i++) cmd_pending.push_back(rand_cmd());
      drain();
    end

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sowtc_pkg.sv
hw/rtl/sowtc_queue.sv
hw/rtl/sowtc_back.sv
hw/rtl/selectable_org_write_through_cache.sv
dv/tb.sv
